### sv/dcfp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcfp_pkg
// Shared constants, types and helpers of the delimited command frame parser.
// ----------------------------------------------------------------------------
package dcfp_pkg;

  localparam int TARGET_BYTES = 3;   // 3 .. 8
  localparam int VALUE_BYTES  = 8;   // 1 .. 8

  localparam int TCNT_W = $clog2(TARGET_BYTES + 1);
  localparam int TIDX_W = $clog2(TARGET_BYTES);
  localparam int VIDX_W = (VALUE_BYTES > 1) ? $clog2(VALUE_BYTES) : 1;

  localparam logic [7:0] CH_SEMI    = 8'h3B;  // ';'
  localparam logic [7:0] CH_COLON   = 8'h3A;  // ':'
  localparam logic [7:0] CH_PAREN   = 8'h29;  // ')'
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_ZERO    = 8'h30;

  localparam logic OUTCOME_DONE  = 1'b0;
  localparam logic OUTCOME_ERROR = 1'b1;

  // phase flag bits
  localparam int PH_TARGET  = 0;
  localparam int PH_COMMAND = 1;
  localparam int PH_LENGTH  = 2;
  localparam int PH_VALUE   = 3;
  localparam int PH_W       = 4;

  localparam int OUT_DATA_W = 112;  // 105 payload bits padded to bytes

  typedef struct packed {
    logic        outcome;
    logic [7:0]  target_first;
    logic [7:0]  target_second;
    logic [7:0]  target_third;
    logic [7:0]  command_number;
    logic [7:0]  value_length;
    logic [63:0] value_data;
    logic        overflow;
  } dcfp_result_t;

  // acc*10 + (b - '0'), modulo 256
  function automatic logic [7:0] fold_digit(input logic [7:0] acc, input logic [7:0] b);
    fold_digit = {acc[4:0], 3'b000} + {acc[6:0], 1'b0} + (b - CH_ZERO);
  endfunction

endpackage

### sv/dcfp_in_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcfp_in_reg
// Input register: holds one received byte until the parser consumes it.
// ----------------------------------------------------------------------------
module dcfp_in_reg import dcfp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic       consume,
  output logic       byte_valid,
  output logic [7:0] byte_data
);

  logic       valid_r, valid_nxt;
  logic [7:0] data_r;

  assign in_tready  = !valid_r || consume;
  assign valid_nxt  = (in_tvalid && in_tready) || (valid_r && !consume);
  assign byte_valid = valid_r;
  assign byte_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      data_r <= in_tdata;
    end
  end

endmodule

### sv/dcfp_parse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcfp_parse
// Frame state and per-byte update; raises a result on the byte after the value.
// ----------------------------------------------------------------------------
module dcfp_parse import dcfp_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         step,
  input  logic [7:0]   rx_byte,
  output logic         res_valid,
  output dcfp_result_t res
);

  logic [PH_W-1:0]   flags_r, flags_nxt;
  logic [7:0]        target_r [TARGET_BYTES];
  logic [7:0]        target_nxt [TARGET_BYTES];
  logic [TCNT_W-1:0] tcnt_r, tcnt_nxt;
  logic [7:0]        cmd_r, cmd_nxt;
  logic [7:0]        lacc_r, lacc_nxt;
  logic [7:0]        len_r, len_nxt;
  logic [7:0]        value_r [VALUE_BYTES];
  logic [7:0]        value_nxt [VALUE_BYTES];
  logic [7:0]        vcnt_r, vcnt_nxt;
  logic              ovf_r, ovf_nxt;
  logic              frame_end;
  logic [63:0]       value_data;

  always_comb begin
    value_data = '0;
    for (int i = 0; i < VALUE_BYTES; i++) begin
      value_data[8*i +: 8] = value_r[i];
    end
  end

  always_comb begin
    flags_nxt  = flags_r;
    target_nxt = target_r;
    tcnt_nxt   = tcnt_r;
    cmd_nxt    = cmd_r;
    lacc_nxt   = lacc_r;
    len_nxt    = len_r;
    value_nxt  = value_r;
    vcnt_nxt   = vcnt_r;
    ovf_nxt    = ovf_r;
    frame_end  = 1'b0;
    res_valid  = 1'b0;
    res        = '0;

    priority if (rx_byte == CH_SEMI) begin
      flags_nxt[PH_TARGET] = 1'b1;
    end else if (rx_byte == CH_COLON) begin
      flags_nxt[PH_COMMAND] = 1'b1;
    end else if (rx_byte == CH_PAREN) begin
      flags_nxt[PH_LENGTH] = 1'b1;
      len_nxt = lacc_r;
    end else if (!flags_r[PH_TARGET]) begin
      if (tcnt_r < TCNT_W'(TARGET_BYTES)) begin
        target_nxt[tcnt_r[TIDX_W-1:0]] = rx_byte;
        tcnt_nxt = tcnt_r + 1'b1;
      end else begin
        ovf_nxt = 1'b1;
      end
    end else if (!flags_r[PH_COMMAND]) begin
      cmd_nxt = fold_digit(cmd_r, rx_byte);
    end else if (!flags_r[PH_LENGTH]) begin
      lacc_nxt = fold_digit(lacc_r, rx_byte);
    end else if (!flags_r[PH_VALUE]) begin
      if (vcnt_r < 8'(VALUE_BYTES)) begin
        value_nxt[vcnt_r[VIDX_W-1:0]] = rx_byte;
      end else begin
        ovf_nxt = 1'b1;
      end
      vcnt_nxt = vcnt_r + 8'd1;
      if (vcnt_nxt >= len_r) begin
        flags_nxt[PH_VALUE] = 1'b1;
      end
    end else begin
      frame_end = 1'b1;
      res_valid = 1'b1;
      if (rx_byte == CH_NEWLINE) begin
        // unwritten store entries are still zero from the last clear
        res.outcome        = OUTCOME_DONE;
        res.target_first   = target_r[0];
        res.target_second  = target_r[1];
        res.target_third   = target_r[2];
        res.command_number = cmd_r;
        res.value_length   = len_r;
        res.value_data     = value_data;
        res.overflow       = ovf_r;
      end else begin
        res.outcome = OUTCOME_ERROR;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && frame_end)) begin
      flags_r <= '0;
      tcnt_r  <= '0;
      cmd_r   <= '0;
      lacc_r  <= '0;
      len_r   <= '0;
      vcnt_r  <= '0;
      ovf_r   <= 1'b0;
      for (int i = 0; i < TARGET_BYTES; i++) target_r[i] <= '0;
      for (int i = 0; i < VALUE_BYTES; i++) value_r[i] <= '0;
    end else if (step) begin
      flags_r  <= flags_nxt;
      tcnt_r   <= tcnt_nxt;
      cmd_r    <= cmd_nxt;
      lacc_r   <= lacc_nxt;
      len_r    <= len_nxt;
      vcnt_r   <= vcnt_nxt;
      ovf_r    <= ovf_nxt;
      target_r <= target_nxt;
      value_r  <= value_nxt;
    end
  end

endmodule

### sv/dcfp_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcfp_out_reg
// Result register: holds one finished result until the sink takes it.
// ----------------------------------------------------------------------------
module dcfp_out_reg import dcfp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  dcfp_result_t          res,
  output logic                  room,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tuser
);

  logic         valid_r, valid_nxt;
  dcfp_result_t res_r;

  assign room      = !valid_r || out_tready;
  assign valid_nxt = push || (valid_r && !out_tready);

  assign out_tvalid = valid_r;
  assign out_tuser  = res_r.outcome;
  assign out_tdata  = {7'd0, res_r.overflow, res_r.value_data, res_r.value_length,
                       res_r.command_number, res_r.target_third, res_r.target_second,
                       res_r.target_first};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      res_r <= res;
    end
  end

endmodule

### sv/delimited_command_frame_parser_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delimited_command_frame_parser_core
// Parses target;command:length)value<newline> frames one byte per request.
// ----------------------------------------------------------------------------
//  channel | ports                           | request
//  --------+---------------------------------+----------------------------------
//  in      | in_tvalid in_tready in_tdata    | one received byte
//  out     | out_tvalid out_tready out_tdata | frame complete or framing error
//          | out_tuser                       |
//
//  one byte per cycle while the out side does not stall; an accepted byte waits
//  in the input register, is parsed from there, and its result enters the result
//  register, which offers it on out until the sink takes it.
//  the frame state update is the single path between the two registers.
//  rst_n (synchronous) clears the frame state and both valid flags.
//  a stalled out side holds the parser; the input register still takes one
//  more byte.
// ----------------------------------------------------------------------------
module delimited_command_frame_parser_core import dcfp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,    // [7:0] rx_byte
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,   // [7:0] target_first, [15:8] target_second,
                                             // [23:16] target_third, [31:24] command_number,
                                             // [39:32] value_length, [103:40] value_data,
                                             // [104] overflow, [111:105] zero
  output logic                  out_tuser    // [0] outcome
);

  logic         byte_valid;
  logic [7:0]   byte_data;
  logic         room;
  logic         step;
  logic         res_valid;
  dcfp_result_t res;

  // a byte is parsed only when the result register can take whatever it makes
  assign step = byte_valid && room;

  dcfp_in_reg u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .consume    (step),
    .byte_valid (byte_valid),
    .byte_data  (byte_data)
  );

  dcfp_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .rx_byte   (byte_data),
    .res_valid (res_valid),
    .res       (res)
  );

  dcfp_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (step && res_valid),
    .res        (res),
    .room       (room),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
